// ===== rtl/max_line_hull_table_assert.svh =====
// assertion macros used by the line hull table rtl
`ifndef MAX_LINE_HULL_TABLE_ASSERT_SVH
`define MAX_LINE_HULL_TABLE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define MLHT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define MLHT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/mlht_pkg.sv =====
// types and constants of the line hull table
`timescale 1ns / 1ps
package mlht_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int COEF_W   = 32;
  localparam int DIFF_W   = COEF_W + 1;
  localparam int BP_W     = COEF_W + 2;
  localparam int VAL_W    = 2 * COEF_W;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;
  localparam int STAT_W     = 2;

  localparam logic signed [BP_W-1:0] BP_POS_INF = {1'b0, {(BP_W-1){1'b1}}};
  localparam logic signed [BP_W-1:0] BP_NEG_INF = -BP_POS_INF;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_SCAN_CMP, S_SH_RD, S_SH_WR, S_INS_WR,
    S_SET_RD_I, S_SET_RD_J, S_SET_CALC, S_DIV, S_SET_WR,
    S_RM_RD, S_RM_WR, S_LP_RD_Y, S_LP_RD_X, S_LP_CMP,
    S_Q_RD, S_Q_CMP, S_Q_EV, S_Q_ADD, S_DONE
  } state_t;

  // what a breakpoint update is part of
  typedef enum logic [1:0] {
    PH_FWD, PH_BACK1, PH_BACK2, PH_LOOP
  } phase_t;

endpackage

// ===== rtl/max_line_hull_table.sv =====
// top level of the line hull table: upper envelope of lines, sequenced over one table memory
`timescale 1ns / 1ps
//
//  channel | ports                        | contents
//  --------+------------------------------+------------------------------------------
//  in      | in_tvalid/in_tready/tdata/tuser | insert a line or query the envelope
//  out     | out_tvalid/out_tready/tdata/tuser | envelope value and status, one per request
//
//  a query walks the stored lines to the first whose breakpoint reaches x; an insert scans
//  lines, moves lines and updates breakpoints, each update that divides running the
//  one-bit-a-cycle restoring divider (no divide when the slopes are equal)
//  rst_n is synchronous: the table empties, stored entries keep stale data
//  in_tready is high only while the sequencer is idle; a finished result waits in the
//  output register and the next transaction may be taken meanwhile
module max_line_hull_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // line_slope [31:0], line_intercept [63:32], query_point [95:64]
  input  logic [mlht_pkg::IN_DATA_W-1:0] in_tdata,
  // req_type
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // envelope_value [63:0]
  output logic [mlht_pkg::OUT_DATA_W-1:0] out_tdata,
  // status [1:0]
  output logic [mlht_pkg::STAT_W-1:0]    out_tuser
);
  import mlht_pkg::*;

  `include "max_line_hull_table_assert.svh"

  // table memory, one entry per line, sorted by slope
  logic signed [COEF_W-1:0] slope_mem [CAPACITY];
  logic signed [COEF_W-1:0] icpt_mem  [CAPACITY];
  logic signed [BP_W-1:0]   bp_mem    [CAPACITY];

  logic [IDX_W-1:0]         rd_addr;
  logic signed [COEF_W-1:0] rd_slope_r, rd_icpt_r;
  logic signed [BP_W-1:0]   rd_bp_r;
  logic                     we_coef, we_bp;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [COEF_W-1:0] wr_slope, wr_icpt;
  logic signed [BP_W-1:0]   wr_bp;

  always_ff @(posedge clk) begin
    rd_slope_r <= slope_mem[rd_addr];
    rd_icpt_r  <= icpt_mem[rd_addr];
    rd_bp_r    <= bp_mem[rd_addr];
    if (we_coef) begin
      slope_mem[wr_addr] <= wr_slope;
      icpt_mem[wr_addr]  <= wr_icpt;
    end
    if (we_bp) begin
      bp_mem[wr_addr] <= wr_bp;
    end
  end

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt, t_r, t_nxt;
  logic signed [COEF_W-1:0] k_r, k_nxt, m_r, m_nxt, x_r, x_nxt;
  logic signed [COEF_W-1:0] ei_slope_r, ei_slope_nxt, ei_icpt_r, ei_icpt_nxt;
  logic signed [BP_W-1:0]   ejbp_r, ejbp_nxt, bp_r, bp_nxt;
  // divider
  logic                     neg_r, neg_nxt;
  logic [DIFF_W-1:0]        quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [DIFF_W:0]          rem_r, rem_nxt;
  logic [5:0]               dcnt_r, dcnt_nxt;
  // query arithmetic and result
  logic signed [VAL_W-1:0]  prod_r, prod_nxt, res_val_r, res_val_nxt;
  logic signed [COEF_W-1:0] ic_r, ic_nxt;
  logic [STAT_W-1:0]        res_st_r, res_st_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]         out_val_r, out_val_nxt;
  logic [STAT_W-1:0]        out_st_r, out_st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_FWD;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r <= i_nxt;  j_r <= j_nxt;  t_r <= t_nxt;
    k_r <= k_nxt;  m_r <= m_nxt;  x_r <= x_nxt;
    ei_slope_r <= ei_slope_nxt;  ei_icpt_r <= ei_icpt_nxt;
    ejbp_r <= ejbp_nxt;  bp_r <= bp_nxt;
    neg_r <= neg_nxt;  quo_r <= quo_nxt;  dvs_r <= dvs_nxt;  rem_r <= rem_nxt;
    prod_r <= prod_nxt;  ic_r <= ic_nxt;
    res_val_r <= res_val_nxt;  res_st_r <= res_st_nxt;
    out_val_r <= out_val_nxt;  out_st_r <= out_st_nxt;
  end

  logic signed [DIFF_W-1:0] num_s, den_s;
  logic [DIFF_W:0]          rem_sh, rem_diff;
  logic signed [BP_W-1:0]   x_ext;
  logic signed [VAL_W-1:0]  mul_full;
  logic                     sd, sf;
  logic [CNT_W-1:0]         i_ext;

  assign num_s    = DIFF_W'(rd_icpt_r) - DIFF_W'(ei_icpt_r);
  assign den_s    = DIFF_W'(ei_slope_r) - DIFF_W'(rd_slope_r);
  assign rem_sh   = {rem_r[DIFF_W-1:0], quo_r[DIFF_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign x_ext    = BP_W'(x_r);
  assign mul_full = rd_slope_r * x_r;
  assign i_ext    = {1'b0, i_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_st_r;

  always_comb begin
    state_nxt = state_r;  phase_nxt = phase_r;  cnt_nxt = cnt_r;
    i_nxt = i_r;  j_nxt = j_r;  t_nxt = t_r;
    k_nxt = k_r;  m_nxt = m_r;  x_nxt = x_r;
    ei_slope_nxt = ei_slope_r;  ei_icpt_nxt = ei_icpt_r;
    ejbp_nxt = ejbp_r;  bp_nxt = bp_r;
    neg_nxt = neg_r;  quo_nxt = quo_r;  dvs_nxt = dvs_r;  rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    prod_nxt = prod_r;  ic_nxt = ic_r;
    res_val_nxt = res_val_r;  res_st_nxt = res_st_r;
    out_val_nxt = out_val_r;  out_st_nxt = out_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_addr = i_r;
    we_coef = 1'b0;  we_bp = 1'b0;  wr_addr = i_r;
    wr_slope = rd_slope_r;  wr_icpt = rd_icpt_r;  wr_bp = rd_bp_r;
    sd = 1'b0;  sf = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_val_nxt = '0;
          res_st_nxt  = ST_OK;
          i_nxt       = '0;
          if (in_tuser == REQ_INSERT) begin
            k_nxt = in_tdata[31:0];
            m_nxt = in_tdata[63:32];
            if (cnt_r == CNT_W'(CAPACITY)) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            x_nxt = in_tdata[95:64];
            if (cnt_r == '0) begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_Q_RD;
            end
          end
        end
      end
      // find the slot after all lines of smaller or equal slope
      S_SCAN: begin
        if (i_ext < cnt_r) begin
          state_nxt = S_SCAN_CMP;
        end else begin
          t_nxt     = cnt_r;
          state_nxt = S_SH_RD;
        end
      end
      S_SCAN_CMP: begin
        if (rd_slope_r <= k_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SCAN;
        end else begin
          t_nxt     = cnt_r;
          state_nxt = S_SH_RD;
        end
      end
      // open the slot, moving entries up from the top
      S_SH_RD: begin
        rd_addr = IDX_W'(t_r - 1'b1);
        if (t_r > i_ext) begin
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_SH_WR: begin
        we_coef   = 1'b1;
        we_bp     = 1'b1;
        wr_addr   = t_r[IDX_W-1:0];
        t_nxt     = t_r - 1'b1;
        state_nxt = S_SH_RD;
      end
      S_INS_WR: begin
        we_coef   = 1'b1;
        we_bp     = 1'b1;
        wr_slope  = k_r;
        wr_icpt   = m_r;
        wr_bp     = '0;
        cnt_nxt   = cnt_r + 1'b1;
        j_nxt     = i_ext + 1'b1;
        phase_nxt = PH_FWD;
        state_nxt = S_SET_RD_I;
      end
      // breakpoint of entry i against entry j
      S_SET_RD_I: begin
        if (j_r >= cnt_r) begin
          we_bp = 1'b1;
          wr_bp = BP_POS_INF;
          sd    = 1'b1;
        end else begin
          state_nxt = S_SET_RD_J;
        end
      end
      S_SET_RD_J: begin
        ei_slope_nxt = rd_slope_r;
        ei_icpt_nxt  = rd_icpt_r;
        rd_addr      = j_r[IDX_W-1:0];
        state_nxt    = S_SET_CALC;
      end
      S_SET_CALC: begin
        ejbp_nxt = rd_bp_r;
        if (rd_slope_r == ei_slope_r) begin
          bp_nxt    = (ei_icpt_r > rd_icpt_r) ? BP_POS_INF : BP_NEG_INF;
          state_nxt = S_SET_WR;
        end else begin
          neg_nxt   = num_s[DIFF_W-1] ^ den_s[DIFF_W-1];
          quo_nxt   = num_s[DIFF_W-1] ? DIFF_W'(-num_s) : DIFF_W'(num_s);
          dvs_nxt   = den_s[DIFF_W-1] ? DIFF_W'(-den_s) : DIFF_W'(den_s);
          rem_nxt   = '0;
          dcnt_nxt  = 6'(DIFF_W);
          state_nxt = S_DIV;
        end
      end
      // restoring division on magnitudes, then floor toward minus infinity
      S_DIV: begin
        if (dcnt_r != '0) begin
          dcnt_nxt = dcnt_r - 1'b1;
          if (!rem_diff[DIFF_W]) begin
            rem_nxt = rem_diff;
            quo_nxt = {quo_r[DIFF_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            quo_nxt = {quo_r[DIFF_W-2:0], 1'b0};
          end
        end else begin
          if (neg_r) begin
            bp_nxt = -(BP_W'(quo_r) + BP_W'(rem_r != '0));
          end else begin
            bp_nxt = BP_W'(quo_r);
          end
          state_nxt = S_SET_WR;
        end
      end
      S_SET_WR: begin
        we_bp = 1'b1;
        wr_bp = bp_r;
        sd    = 1'b1;
        sf    = (bp_r >= ejbp_r);
      end
      // drop entry t, moving the entries above it down
      S_RM_RD: begin
        rd_addr = IDX_W'(t_r + 1'b1);
        if ((t_r + 1'b1) < cnt_r) begin
          state_nxt = S_RM_WR;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          phase_nxt = (phase_r == PH_BACK1) ? PH_BACK2 : phase_r;
          state_nxt = S_SET_RD_I;
        end
      end
      S_RM_WR: begin
        we_coef   = 1'b1;
        we_bp     = 1'b1;
        wr_addr   = t_r[IDX_W-1:0];
        t_nxt     = t_r + 1'b1;
        state_nxt = S_RM_RD;
      end
      // backward sweep: entry j against entry i just below it
      S_LP_RD_Y: begin
        rd_addr   = j_r[IDX_W-1:0];
        state_nxt = S_LP_RD_X;
      end
      S_LP_RD_X: begin
        ejbp_nxt  = rd_bp_r;
        state_nxt = S_LP_CMP;
      end
      S_LP_CMP: begin
        if (rd_bp_r < ejbp_r) begin
          state_nxt = S_DONE;
        end else begin
          phase_nxt = PH_LOOP;
          t_nxt     = j_r;
          state_nxt = S_RM_RD;
        end
      end
      // query: first line whose breakpoint reaches x
      S_Q_RD: begin
        if ((i_ext + 1'b1) < cnt_r) begin
          state_nxt = S_Q_CMP;
        end else begin
          state_nxt = S_Q_EV;
        end
      end
      S_Q_CMP: begin
        if (rd_bp_r < x_ext) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_Q_RD;
        end else begin
          prod_nxt  = mul_full;
          ic_nxt    = rd_icpt_r;
          state_nxt = S_Q_ADD;
        end
      end
      S_Q_EV: begin
        prod_nxt  = mul_full;
        ic_nxt    = rd_icpt_r;
        state_nxt = S_Q_ADD;
      end
      S_Q_ADD: begin
        res_val_nxt = prod_r + VAL_W'(ic_r);
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // continuation after a breakpoint update
    if (sd) begin
      case (phase_r)
        PH_FWD: begin
          if (sf) begin
            t_nxt     = j_r;
            state_nxt = S_RM_RD;
          end else if (i_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            j_nxt     = i_ext;
            i_nxt     = i_r - 1'b1;
            phase_nxt = PH_BACK1;
            state_nxt = S_SET_RD_I;
          end
        end
        PH_BACK1: begin
          if (sf) begin
            t_nxt     = j_r;
            state_nxt = S_RM_RD;
          end else if (i_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            j_nxt     = i_ext;
            i_nxt     = i_r - 1'b1;
            state_nxt = S_LP_RD_Y;
          end
        end
        default: begin
          if (i_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            j_nxt     = i_ext;
            i_nxt     = i_r - 1'b1;
            state_nxt = S_LP_RD_Y;
          end
        end
      endcase
    end
  end

  `MLHT_CHECK(a_cnt_cap, cnt_r <= CNT_W'(CAPACITY), "line count above capacity")
  `MLHT_IMPLIES(a_div_busy, dcnt_r != '0, state_r == S_DIV, "divider running outside divide")
  `MLHT_IMPLIES(a_cnt_step, cnt_r != $past(cnt_r), ($past(state_r) == S_INS_WR) || ($past(state_r) == S_RM_RD), "line count changed outside insert or remove")
  `MLHT_IMPLIES(a_out_load, $rose(out_tvalid), $past(state_r) == S_DONE, "result appeared without finishing a request")

endmodule
